// File: hw/rtl/sprt_pkg.sv
package sprt_pkg;

  localparam int STAT_BITS = 48;
  // (x+k)^2 fits in 50 bits for sample widths up to 24 bits; minus gamma needs one more
  localparam int TERM_BITS = 51;
  localparam int ACC_BITS  = 52;

  localparam int K_BITS     = 16;
  localparam int GAMMA_BITS = 39;
  localparam int LIMIT_BITS = 40;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 40;

  localparam int MID_DEPTH = 8;
  localparam int OUT_DEPTH = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_K = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAMMA    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOWER    = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UPPER    = 2'd3;

  localparam logic [GAMMA_BITS-1:0]        GAMMA_RST = 39'd16777216;
  localparam logic signed [LIMIT_BITS-1:0] LOWER_RST = -40'sd16777216;
  localparam logic signed [LIMIT_BITS-1:0] UPPER_RST = 40'sd83886080;

  typedef enum logic [1:0] {
    DEC_CONTINUE = 2'd0,
    DEC_ACCEPT   = 2'd1,
    DEC_SIGNAL   = 2'd2
  } decision_t;

  localparam int DEC_BITS = 2;

endpackage

// File: hw/rtl/sprt_fifo.sv
module sprt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [WIDTH-1:0]         wdata,
  output logic                     full,
  input  logic                     pop,
  output logic [WIDTH-1:0]         rdata,
  output logic                     empty,
  output logic [$clog2(DEPTH):0]   count
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH) + 1;

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full  = (cnt_r == CNT_BITS'(DEPTH));
  assign empty = (cnt_r == '0);
  assign count = cnt_r;
  assign rdata = mem_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: hw/rtl/sprt_front.sv
module sprt_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_valid,
  input  logic signed [SAMPLE_BITS-1:0]                sample,
  input  logic signed [sprt_pkg::K_BITS-1:0]           offset_k,
  input  logic [sprt_pkg::GAMMA_BITS-1:0]              gamma,
  output logic                                         term_valid,
  output logic signed [sprt_pkg::TERM_BITS-1:0]        term,
  output logic [1:0]                                   inflight
);

  import sprt_pkg::*;

  localparam int SUM_BITS  = ((SAMPLE_BITS > K_BITS) ? SAMPLE_BITS : K_BITS) + 1;
  localparam int PROD_BITS = 2 * SUM_BITS;

  logic                        v1_r, v2_r, v3_r;
  logic signed [SUM_BITS-1:0]  sum_r, sum_nxt;
  logic signed [PROD_BITS-1:0] prod_r, prod_nxt;
  logic signed [TERM_BITS-1:0] term_r, term_nxt;

  assign sum_nxt  = SUM_BITS'(sample) + SUM_BITS'(offset_k);
  assign prod_nxt = sum_r * sum_r;
  // square is never negative, so widening keeps the value
  assign term_nxt = TERM_BITS'(prod_r) - TERM_BITS'($signed({1'b0, gamma}));

  assign term_valid = v3_r;
  assign term       = term_r;
  assign inflight   = 2'(v1_r) + 2'(v2_r) + 2'(v3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    prod_r <= prod_nxt;
    term_r <= term_nxt;
  end

endmodule

// File: hw/rtl/sprt_back.sv
module sprt_back #(
  parameter int COUNT_BITS = 24
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       take,
  input  logic signed [sprt_pkg::TERM_BITS-1:0]      term,
  input  logic signed [sprt_pkg::LIMIT_BITS-1:0]     lower_limit,
  input  logic signed [sprt_pkg::LIMIT_BITS-1:0]     upper_limit,
  output sprt_pkg::decision_t                        decision,
  output logic signed [sprt_pkg::STAT_BITS-1:0]      statistic,
  output logic [COUNT_BITS-1:0]                      sequence_samples,
  output logic [COUNT_BITS-1:0]                      run_sequences,
  output logic [COUNT_BITS-1:0]                      run_samples
);

  import sprt_pkg::*;

  localparam logic signed [STAT_BITS-1:0] STAT_MAX = {1'b0, {(STAT_BITS-1){1'b1}}};
  localparam logic signed [STAT_BITS-1:0] STAT_MIN = {1'b1, {(STAT_BITS-1){1'b0}}};

  logic signed [STAT_BITS-1:0] stat_r, stat_nxt;
  logic [COUNT_BITS-1:0]       seq_cnt_r, seq_cnt_nxt;
  logic [COUNT_BITS-1:0]       run_seq_r, run_seq_nxt;
  logic [COUNT_BITS-1:0]       run_smp_r, run_smp_nxt;

  logic signed [ACC_BITS-1:0]  acc;
  logic signed [STAT_BITS-1:0] sat;
  logic                        ovf;
  logic [COUNT_BITS-1:0]       seq_inc, run_seq_inc, run_smp_inc;

  assign acc = ACC_BITS'(stat_r) + ACC_BITS'(term);
  // overflow when the bits above the statistic's sign do not all match it
  assign ovf = !((&acc[ACC_BITS-1:STAT_BITS-1]) || !(|acc[ACC_BITS-1:STAT_BITS-1]));
  assign sat = ovf ? (acc[ACC_BITS-1] ? STAT_MIN : STAT_MAX) : acc[STAT_BITS-1:0];

  assign seq_inc     = (&seq_cnt_r) ? seq_cnt_r : seq_cnt_r + 1'b1;
  assign run_smp_inc = (&run_smp_r) ? run_smp_r : run_smp_r + 1'b1;
  assign run_seq_inc = (seq_cnt_r != '0) ? run_seq_r :
                       ((&run_seq_r) ? run_seq_r : run_seq_r + 1'b1);

  always_comb begin
    // signal wins when both limits are crossed
    if (sat > STAT_BITS'(upper_limit)) begin
      decision = DEC_SIGNAL;
    end else if (sat < STAT_BITS'(lower_limit)) begin
      decision = DEC_ACCEPT;
    end else begin
      decision = DEC_CONTINUE;
    end
  end

  assign statistic        = sat;
  assign sequence_samples = seq_inc;
  assign run_sequences    = run_seq_inc;
  assign run_samples      = run_smp_inc;

  always_comb begin
    stat_nxt    = stat_r;
    seq_cnt_nxt = seq_cnt_r;
    run_seq_nxt = run_seq_r;
    run_smp_nxt = run_smp_r;
    if (take) begin
      unique case (decision)
        DEC_SIGNAL: begin
          stat_nxt    = '0;
          seq_cnt_nxt = '0;
          run_seq_nxt = '0;
          run_smp_nxt = '0;
        end
        DEC_ACCEPT: begin
          stat_nxt    = '0;
          seq_cnt_nxt = '0;
          run_seq_nxt = run_seq_inc;
          run_smp_nxt = run_smp_inc;
        end
        default: begin
          stat_nxt    = sat;
          seq_cnt_nxt = seq_inc;
          run_seq_nxt = run_seq_inc;
          run_smp_nxt = run_smp_inc;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat_r    <= '0;
      seq_cnt_r <= '0;
      run_seq_r <= '0;
      run_smp_r <= '0;
    end else begin
      stat_r    <= stat_nxt;
      seq_cnt_r <= seq_cnt_nxt;
      run_seq_r <= run_seq_nxt;
      run_smp_r <= run_smp_nxt;
    end
  end

endmodule

// File: hw/rtl/sprt_chart_monitor_core.sv
// Channel  Ports                                          Beat when
// input    in_push, in_full, in_sample                    in_push && !in_full
// result   out_pop, out_empty, out_decision, out_statistic,
//          out_sequence_samples, out_run_sequences,
//          out_run_samples                                out_pop && !out_empty
// config   cfg_we, cfg_index, cfg_wdata                   cfg_we
//
// One sample per cycle sustained while results are popped. A result passes three
// front stages (offset, square, gamma) and the middle queue; the accumulator loop,
// one add and saturate per cycle while the result queue has room, writes it there.
// Synchronous active-low reset clears all state and loads the register defaults.
// in_full rises when the middle queue plus the front stages in flight would
// overflow; a stalled result side backs up through the queues to in_full.
module sprt_chart_monitor_core #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 24
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_push,
  output logic                                    in_full,
  input  logic signed [SAMPLE_BITS-1:0]           in_sample,
  output logic                                    out_empty,
  input  logic                                    out_pop,
  output logic [sprt_pkg::DEC_BITS-1:0]           out_decision,
  output logic signed [sprt_pkg::STAT_BITS-1:0]   out_statistic,
  output logic [COUNT_BITS-1:0]                   out_sequence_samples,
  output logic [COUNT_BITS-1:0]                   out_run_sequences,
  output logic [COUNT_BITS-1:0]                   out_run_samples,
  input  logic                                    cfg_we,
  input  logic [sprt_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [sprt_pkg::CFG_DATA_BITS-1:0]      cfg_wdata
);

  import sprt_pkg::*;

  localparam int MID_CNT_BITS = $clog2(MID_DEPTH) + 1;
  localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH) + 1;
  localparam int CREDIT_BITS  = MID_CNT_BITS + 1;
  localparam int RES_BITS     = DEC_BITS + STAT_BITS + 3 * COUNT_BITS;

  logic signed [K_BITS-1:0]     offset_k_r;
  logic [GAMMA_BITS-1:0]        gamma_r;
  logic signed [LIMIT_BITS-1:0] lower_r;
  logic signed [LIMIT_BITS-1:0] upper_r;

  logic                        accept;
  logic                        term_valid;
  logic signed [TERM_BITS-1:0] front_term;
  logic [1:0]                  inflight;

  logic                        mid_full, mid_empty;
  logic [TERM_BITS-1:0]        mid_rdata;
  logic [MID_CNT_BITS-1:0]     mid_count;
  logic [CREDIT_BITS-1:0]      credit;

  logic                        take;
  logic                        res_full;
  decision_t                   res_decision;
  logic signed [STAT_BITS-1:0] res_statistic;
  logic [COUNT_BITS-1:0]       res_seq, res_run_seq, res_run_smp;
  logic [RES_BITS-1:0]         res_wdata, res_rdata;
  logic [OUT_CNT_BITS-1:0]     res_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_k_r <= '0;
      gamma_r    <= GAMMA_RST;
      lower_r    <= LOWER_RST;
      upper_r    <= UPPER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET_K: offset_k_r <= cfg_wdata[K_BITS-1:0];
        CFG_GAMMA:    gamma_r    <= cfg_wdata[GAMMA_BITS-1:0];
        CFG_LOWER:    lower_r    <= cfg_wdata[LIMIT_BITS-1:0];
        CFG_UPPER:    upper_r    <= cfg_wdata[LIMIT_BITS-1:0];
        default:      ;
      endcase
    end
  end

  // reserve a middle-queue slot for every beat still in the front stages
  assign credit  = CREDIT_BITS'(mid_count) + CREDIT_BITS'(inflight);
  assign in_full = (credit >= CREDIT_BITS'(MID_DEPTH));
  assign accept  = in_push && !in_full;

  sprt_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (accept),
    .sample     (in_sample),
    .offset_k   (offset_k_r),
    .gamma      (gamma_r),
    .term_valid (term_valid),
    .term       (front_term),
    .inflight   (inflight)
  );

  sprt_fifo #(
    .WIDTH(TERM_BITS),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (term_valid),
    .wdata (front_term),
    .full  (mid_full),
    .pop   (take),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .count (mid_count)
  );

  assign take = !mid_empty && !res_full;

  sprt_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .take             (take),
    .term             ($signed(mid_rdata)),
    .lower_limit      (lower_r),
    .upper_limit      (upper_r),
    .decision         (res_decision),
    .statistic        (res_statistic),
    .sequence_samples (res_seq),
    .run_sequences    (res_run_seq),
    .run_samples      (res_run_smp)
  );

  assign res_wdata = {res_decision, res_statistic, res_seq, res_run_seq, res_run_smp};

  sprt_fifo #(
    .WIDTH(RES_BITS),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (take),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty),
    .count (res_count)
  );

  assign out_decision         = res_rdata[RES_BITS-1 -: DEC_BITS];
  assign out_statistic        = res_rdata[3*COUNT_BITS +: STAT_BITS];
  assign out_sequence_samples = res_rdata[2*COUNT_BITS +: COUNT_BITS];
  assign out_run_sequences    = res_rdata[COUNT_BITS +: COUNT_BITS];
  assign out_run_samples      = res_rdata[0 +: COUNT_BITS];

  // credit check keeps the middle queue from overflowing, so its full flag is not needed
  logic unused_status;
  assign unused_status = mid_full ^ (^res_count);

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sprt_pkg::*;

  localparam int SMP_W    = 16;
  localparam int CNT_W    = 24;
  localparam int WATCHDOG = 2000;
  localparam longint STAT_HI = (longint'(1) <<< (STAT_BITS - 1)) - 1;
  localparam longint STAT_LO = -STAT_HI - 1;

  typedef struct {
    decision_t                    dec;
    logic signed [STAT_BITS-1:0]  stat;
    logic [CNT_W-1:0]             seq_smp;
    logic [CNT_W-1:0]             run_seq;
    logic [CNT_W-1:0]             run_smp;
  } chart_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                    kind;
    logic [CFG_IDX_BITS-1:0]      idx;
    logic [CFG_DATA_BITS-1:0]     data;
    logic signed [SMP_W-1:0]      smp;
    bit                           typed;
    decision_t                    dec;
    logic signed [STAT_BITS-1:0]  stat;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic signed [SMP_W-1:0] in_sample = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [DEC_BITS-1:0] out_decision;
  logic signed [STAT_BITS-1:0] out_statistic;
  logic [CNT_W-1:0] out_sequence_samples;
  logic [CNT_W-1:0] out_run_sequences;
  logic [CNT_W-1:0] out_run_samples;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  // chart model: registers and running state
  logic signed [K_BITS-1:0]     k_reg     = '0;
  logic [GAMMA_BITS-1:0]        gamma_reg = GAMMA_RST;
  logic signed [LIMIT_BITS-1:0] lower_reg = LOWER_RST;
  logic signed [LIMIT_BITS-1:0] upper_reg = UPPER_RST;
  logic signed [STAT_BITS-1:0]  u_reg     = '0;
  logic [CNT_W-1:0]             seq_cnt   = '0;
  logic [CNT_W-1:0]             run_seqs  = '0;
  logic [CNT_W-1:0]             run_cnt   = '0;

  chart_result_t pending_results[$];
  chart_result_t head_result;
  script_row_t   script[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;

  always #5 clk = ~clk;

  sprt_chart_monitor_core #(
    .SAMPLE_BITS(SMP_W),
    .COUNT_BITS (CNT_W)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_sample           (in_sample),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_decision        (out_decision),
    .out_statistic       (out_statistic),
    .out_sequence_samples(out_sequence_samples),
    .out_run_sequences   (out_run_sequences),
    .out_run_samples     (out_run_samples),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  task automatic chart_step(input logic signed [SMP_W-1:0] x, output chart_result_t r);
    longint shifted;
    longint next_u;
    shifted = longint'(x) + longint'(k_reg);
    next_u  = longint'(u_reg) + shifted * shifted - longint'(gamma_reg);
    if (next_u > STAT_HI) next_u = STAT_HI;
    if (next_u < STAT_LO) next_u = STAT_LO;
    // a sample landing on an empty sequence opens a new one
    if (seq_cnt == '0) run_seqs = count_up(run_seqs);
    seq_cnt = count_up(seq_cnt);
    run_cnt = count_up(run_cnt);
    if (next_u > longint'(upper_reg)) r.dec = DEC_SIGNAL;
    else if (next_u < longint'(lower_reg)) r.dec = DEC_ACCEPT;
    else r.dec = DEC_CONTINUE;
    r.stat    = next_u[STAT_BITS-1:0];
    r.seq_smp = seq_cnt;
    r.run_seq = run_seqs;
    r.run_smp = run_cnt;
    case (r.dec)
      DEC_SIGNAL: begin
        u_reg    = '0;
        seq_cnt  = '0;
        run_seqs = '0;
        run_cnt  = '0;
      end
      DEC_ACCEPT: begin
        u_reg   = '0;
        seq_cnt = '0;
      end
      default: u_reg = next_u[STAT_BITS-1:0];
    endcase
  endtask

  function automatic void add_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
    script.insert(script.size(), '{ROW_CFG, idx, data, '0, 1'b0, DEC_CONTINUE, '0});
  endfunction

  function automatic void add_smp(input logic signed [SMP_W-1:0] x, input bit typed,
                                  input decision_t dec, input logic signed [STAT_BITS-1:0] st);
    script.insert(script.size(), '{ROW_SAMPLE, '0, '0, x, typed, dec, st});
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] rand_word();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[CFG_DATA_BITS-1:0];
  endfunction

  function automatic logic signed [SMP_W-1:0] draw_sample(input int drift);
    int v;
    if ($urandom_range(0, 19) == 0) return SMP_W'($urandom_range(0, 65535));
    v = int'($urandom_range(0, 8192)) + int'($urandom_range(0, 8192)) - 8192 + drift;
    return v[SMP_W-1:0];
  endfunction

  task automatic drain();
    in_push = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      CFG_OFFSET_K: k_reg     = data[K_BITS-1:0];
      CFG_GAMMA:    gamma_reg = data[GAMMA_BITS-1:0];
      CFG_LOWER:    lower_reg = data[LIMIT_BITS-1:0];
      CFG_UPPER:    upper_reg = data[LIMIT_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic push_sample(input logic signed [SMP_W-1:0] x, input bit typed,
                             input decision_t typed_dec,
                             input logic signed [STAT_BITS-1:0] typed_stat);
    chart_result_t r;
    while (!no_idle && $urandom_range(0, 99) < 16) begin
      in_push   = 1'b0;
      in_sample = SMP_W'($urandom());
      @(negedge clk);
    end
    in_push   = 1'b1;
    in_sample = x;
    @(posedge clk);
    while (in_full) @(posedge clk);
    chart_step(x, r);
    if (typed) begin
      r.dec  = typed_dec;
      r.stat = typed_stat;
    end
    pending_results.insert(pending_results.size(), r);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) out_pop <= no_idle || ($urandom_range(0, 99) >= 16);

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual stat %0d",
                 $time, out_statistic);
        mismatches++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("decision", longint'(head_result.dec), longint'(out_decision));
        check_field("statistic", longint'(head_result.stat), longint'(out_statistic));
        check_field("sequence_samples", longint'(head_result.seq_smp),
                    longint'(out_sequence_samples));
        check_field("run_sequences", longint'(head_result.run_seq),
                    longint'(out_run_sequences));
        check_field("run_samples", longint'(head_result.run_smp), longint'(out_run_samples));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("%0t: no beat for %0d cycles", $time, idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int drift;
    script_row_t row;

    // reset values: equality with the lower limit, then an accept
    add_smp(16'sh0000, 1'b1, DEC_CONTINUE, -48'sd16777216);
    add_smp(16'sh0000, 1'b1, DEC_ACCEPT,   -48'sd33554432);
    add_smp(16'sh7fff, 1'b1, DEC_SIGNAL,    48'sd1056899073);
    add_smp(16'sh8000, 1'b1, DEC_SIGNAL,    48'sd1056964608);
    // offset extremes
    add_cfg(CFG_OFFSET_K, 40'h0000008000);
    add_smp(16'sh8000, 1'b1, DEC_SIGNAL,    48'sd4278190080);
    add_cfg(CFG_OFFSET_K, 40'h0000007fff);
    add_smp(16'sh7fff, 1'b1, DEC_SIGNAL,    48'sd4277927940);
    // equality with the upper limit
    add_cfg(CFG_OFFSET_K, 40'h0);
    add_cfg(CFG_GAMMA,    40'h0);
    add_cfg(CFG_UPPER,    40'sd16777216);
    add_smp(16'sh1000, 1'b1, DEC_CONTINUE,  48'sd16777216);
    add_smp(16'sh1000, 1'b1, DEC_SIGNAL,    48'sd33554432);
    add_smp(16'shf000, 1'b1, DEC_CONTINUE,  48'sd16777216);
    add_smp(16'sh0001, 1'b0, DEC_CONTINUE,  '0);
    add_cfg(CFG_GAMMA,    40'sd16777216);
    add_smp(16'sh0000, 1'b1, DEC_CONTINUE, -48'sd16777216);
    add_smp(16'sh0000, 1'b1, DEC_ACCEPT,   -48'sd33554432);
    add_smp(16'sh0000, 1'b0, DEC_CONTINUE,  '0);
    // lower limit above the upper one: signal wins
    add_cfg(CFG_GAMMA,    40'h0);
    add_cfg(CFG_LOWER,    40'sd134217728);
    add_cfg(CFG_UPPER,    40'sd33554432);
    add_smp(16'sh0000, 1'b1, DEC_ACCEPT,   -48'sd16777216);
    add_smp(16'sh2000, 1'b1, DEC_SIGNAL,    48'sd67108864);
    // register extremes
    add_cfg(CFG_GAMMA,    40'h7fffffffff);
    add_cfg(CFG_LOWER,    40'h8000000000);
    add_cfg(CFG_UPPER,    40'h7fffffffff);
    add_smp(16'sh0000, 1'b1, DEC_CONTINUE, -48'sd549755813887);
    add_smp(16'sh0000, 1'b1, DEC_ACCEPT,   -48'sd1099511627774);
    add_cfg(CFG_GAMMA,    40'h0);
    add_cfg(CFG_LOWER,    40'h7fffffffff);
    add_cfg(CFG_UPPER,    40'h8000000000);
    add_smp(16'sh0000, 1'b1, DEC_SIGNAL,    48'sd0);
    add_smp(16'sh5a5a, 1'b0, DEC_CONTINUE,  '0);
    add_cfg(CFG_OFFSET_K, 40'h0);
    add_cfg(CFG_GAMMA,    40'(GAMMA_RST));
    add_cfg(CFG_LOWER,    40'(LOWER_RST));
    add_cfg(CFG_UPPER,    40'(UPPER_RST));
    add_smp(16'sh1234, 1'b0, DEC_CONTINUE,  '0);
    add_smp(16'shedcb, 1'b0, DEC_CONTINUE,  '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (script[i]) begin
      row = script[i];
      if (row.kind == ROW_CFG) begin
        drain();
        cfg_write(row.idx, row.data);
      end else begin
        push_sample(row.smp, row.typed, row.dec, row.stat);
      end
    end

    for (int phase = 0; phase < 12; phase++) begin
      drain();
      no_idle = (phase == 5 || phase == 6);
      if (phase % 4 == 3) begin
        // raw words, junk above the offset and gamma register widths included
        cfg_write(CFG_OFFSET_K, rand_word());
        cfg_write(CFG_GAMMA,    rand_word());
        cfg_write(CFG_LOWER,    rand_word());
        cfg_write(CFG_UPPER,    rand_word());
      end else begin
        cfg_write(CFG_OFFSET_K,
                  CFG_DATA_BITS'(int'($urandom_range(0, 4096)) - 2048));
        cfg_write(CFG_GAMMA,    CFG_DATA_BITS'($urandom_range(1 << 22, 1 << 26)));
        cfg_write(CFG_LOWER,    CFG_DATA_BITS'(-int'($urandom_range(0, 8 << 24))));
        cfg_write(CFG_UPPER,    CFG_DATA_BITS'($urandom_range(1 << 24, 12 << 24)));
      end
      drift = int'($urandom_range(0, 6144)) - 3072;
      repeat (102) push_sample(draw_sample(drift), 1'b0, DEC_CONTINUE, '0);
    end

    drain();
    no_idle = 1'b0;
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/sprt_pkg.sv
hw/rtl/sprt_fifo.sv
hw/rtl/sprt_front.sv
hw/rtl/sprt_back.sv
hw/rtl/sprt_chart_monitor_core.sv
tb/tb_top.sv
